### src/scd_pkg.sv
// -----------------------------------------------------------------------------
// scd_pkg
// Types and constants shared by the sum-checked frame deframer.
// -----------------------------------------------------------------------------
package scd_pkg;

   localparam int unsigned BYTE_COUNT_W = 7;

   // Event codes on the request channel
   typedef enum logic [1:0] {
      OP_BYTE     = 2'd0,
      OP_TIMEOUT  = 2'd1,
      OP_OVERFLOW = 2'd2
   } op_type;

   // Result status codes
   typedef enum logic [3:0] {
      ST_TELEMETRY = 4'd0,
      ST_OK        = 4'd1,
      ST_SHORT_LEN = 4'd2,
      ST_LONG_LEN  = 4'd3,
      ST_BAD_END   = 4'd4,
      ST_BAD_SUM   = 4'd5,
      ST_STRAY     = 4'd6,
      ST_TIMEOUT   = 4'd7,
      ST_OVERFLOW  = 4'd8
   } status_type;

   // CSR indexes
   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH   = 2'd2;
   localparam logic [1:0] CSR_TELEM_TOTAL  = 2'd3;

   // CSR reset values
   localparam logic [7:0] START_MARKER_RST = 8'h68;
   localparam logic [7:0] END_MARKER_RST   = 8'h43;
   localparam logic [5:0] MAX_LENGTH_RST   = 6'd62;
   localparam logic [6:0] TELEM_TOTAL_RST  = 7'd14;

   typedef struct packed {
      op_type     operation;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [BYTE_COUNT_W-1:0]   byte_count;
      logic [15:0]               speed_value;
      logic [7:0]                step_count;
      logic [7:0]                computed_sum;
      logic [7:0]                end_seen;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [5:0] max_length_field;
      logic [6:0] telemetry_total;
   } cfg_type;

endpackage

### src/scd_parse.sv
// -----------------------------------------------------------------------------
// scd_parse
// Frame state tracker: one event per cycle while accept is high, running checksum, stray counting.
// -----------------------------------------------------------------------------
module scd_parse #(
   parameter int unsigned STRAY_LIMIT     = 16,
   parameter int unsigned MAX_FRAME_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  scd_pkg::req_type req,
   input  scd_pkg::cfg_type cfg,
   output logic             res_valid,
   output scd_pkg::rsp_type res
);
   import scd_pkg::*;

   localparam int unsigned POS_W   = $clog2(MAX_FRAME_BYTES);
   localparam int unsigned STRAY_W = $clog2(STRAY_LIMIT + 1);

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [5:0]         len_ff,   len_in;
   logic [7:0]         sum_ff,   sum_in;
   logic [7:0]         prior_ff, prior_in;
   logic [7:0]         spd_hi_ff, spd_hi_in;
   logic [7:0]         spd_lo_ff, spd_lo_in;
   logic [7:0]         steps_ff, steps_in;
   logic [STRAY_W-1:0] stray_ff, stray_in;

   logic [BYTE_COUNT_W-1:0] idx;
   logic [BYTE_COUNT_W-1:0] total;
   logic [7:0]              b;

   assign b     = req.byte_value;
   assign idx   = BYTE_COUNT_W'(pos_ff);
   assign total = BYTE_COUNT_W'(len_ff) + BYTE_COUNT_W'(2);

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      prior_in  = prior_ff;
      spd_hi_in = spd_hi_ff;
      spd_lo_in = spd_lo_ff;
      steps_in  = steps_ff;
      stray_in  = stray_ff;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         unique case (req.operation)
            OP_BYTE: begin
               if (pos_ff == '0) begin
                  if (b != cfg.start_marker) begin
                     if (stray_ff >= STRAY_W'(STRAY_LIMIT)) begin
                        res_valid      = 1'b1;
                        res.status     = ST_STRAY;
                        res.byte_count = BYTE_COUNT_W'(stray_ff);
                        stray_in       = STRAY_W'(1);
                     end else begin
                        stray_in = stray_ff + STRAY_W'(1);
                     end
                  end else begin
                     pos_in    = POS_W'(1);
                     sum_in    = '0;
                     len_in    = '0;
                     prior_in  = b;
                     spd_hi_in = '0;
                     spd_lo_in = '0;
                     steps_in  = '0;
                     stray_in  = '0;
                     if (stray_ff != '0) begin
                        res_valid      = 1'b1;
                        res.status     = ST_STRAY;
                        res.byte_count = BYTE_COUNT_W'(stray_ff);
                     end
                  end
               end else if (pos_ff == POS_W'(1)) begin
                  pos_in = '0;
                  if (b < 8'd2) begin
                     res_valid      = 1'b1;
                     res.status     = ST_SHORT_LEN;
                     res.byte_count = BYTE_COUNT_W'(2);
                  end else if ((b > {2'b00, cfg.max_length_field}) ||
                               (({1'b0, b} + 9'd2) > 9'(MAX_FRAME_BYTES))) begin
                     res_valid      = 1'b1;
                     res.status     = ST_LONG_LEN;
                     res.byte_count = BYTE_COUNT_W'(2);
                  end else begin
                     len_in   = b[5:0];
                     sum_in   = b;
                     prior_in = b;
                     pos_in   = POS_W'(2);
                  end
               end else begin
                  // Captures use the fresh byte, so a short shape still decodes
                  if (idx == BYTE_COUNT_W'(3)) spd_hi_in = b;
                  if (idx == BYTE_COUNT_W'(4)) spd_lo_in = b;
                  if (idx == BYTE_COUNT_W'(6)) steps_in  = b;
                  if ((idx + BYTE_COUNT_W'(3)) <= total) sum_in = sum_ff + b;
                  prior_in = b;
                  if ((idx + BYTE_COUNT_W'(1)) < total) begin
                     pos_in = pos_ff + POS_W'(1);
                  end else begin
                     // last byte; prior_ff holds the claimed checksum
                     pos_in           = '0;
                     res_valid        = 1'b1;
                     res.byte_count   = total;
                     res.computed_sum = sum_ff;
                     res.end_seen     = b;
                     priority if (b != cfg.end_marker) begin
                        res.status = ST_BAD_END;
                     end else if (prior_ff != sum_ff) begin
                        res.status = ST_BAD_SUM;
                     end else if (total == cfg.telemetry_total) begin
                        res.status      = ST_TELEMETRY;
                        res.speed_value = {spd_hi_in, spd_lo_in};
                        res.step_count  = steps_in;
                     end else begin
                        res.status = ST_OK;
                     end
                  end
               end
            end
            OP_TIMEOUT, OP_OVERFLOW: begin
               if (pos_ff != '0) begin
                  pos_in         = '0;
                  res_valid      = 1'b1;
                  res.status     = (req.operation == OP_TIMEOUT) ? ST_TIMEOUT : ST_OVERFLOW;
                  res.byte_count = BYTE_COUNT_W'(pos_ff);
               end else if (stray_ff != '0) begin
                  stray_in       = '0;
                  res_valid      = 1'b1;
                  res.status     = ST_STRAY;
                  res.byte_count = BYTE_COUNT_W'(stray_ff);
               end
            end
            default: begin
               // unused event code: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         prior_ff  <= '0;
         spd_hi_ff <= '0;
         spd_lo_ff <= '0;
         steps_ff  <= '0;
         stray_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         prior_ff  <= prior_in;
         spd_hi_ff <= spd_hi_in;
         spd_lo_ff <= spd_lo_in;
         steps_ff  <= steps_in;
         stray_ff  <= stray_in;
      end
   end

endmodule

### src/sum_checked_frame_deframer.sv
// -----------------------------------------------------------------------------
// sum_checked_frame_deframer
// Start/length/checksum/end frame parser with stray-byte grouping and CSRs.
// -----------------------------------------------------------------------------
// Results go to the result register, or to the skid register under rsp_stall.
// Throughput: one event beat per cycle while req_stall is low; parse state updates in a single pass.
// Output is a result register plus one skid register; req_stall rises only
//   while the skid register holds a beat.
// Reset (synchronous, active high) closes any frame, drops held strays,
//   empties the output stage and restores the CSR defaults.
module sum_checked_frame_deframer #(
   parameter int unsigned STRAY_LIMIT     = 16,
   parameter int unsigned MAX_FRAME_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   // event channel
   input  logic             req_valid,
   output logic             req_stall,
   input  scd_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scd_pkg::rsp_type rsp_data,
   // CSR write port
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import scd_pkg::*;

   // CSRs
   logic [7:0] start_marker_ff;
   logic [7:0] end_marker_ff;
   logic [5:0] max_length_ff;
   logic [6:0] telem_total_ff;
   cfg_type    cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
         max_length_ff   <= MAX_LENGTH_RST;
         telem_total_ff  <= TELEM_TOTAL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            CSR_MAX_LENGTH:   max_length_ff   <= csr_wdata[5:0];
            CSR_TELEM_TOTAL:  telem_total_ff  <= csr_wdata[6:0];
         endcase
      end
   end

   assign cfg = '{start_marker:     start_marker_ff,
                  end_marker:       end_marker_ff,
                  max_length_field: max_length_ff,
                  telemetry_total:  telem_total_ff};

   // Parser: state advances on every accepted beat
   logic    accept;
   logic    res_valid;
   rsp_type res;

   scd_parse #(
      .STRAY_LIMIT     (STRAY_LIMIT),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output stage: result register backed by one skid register.
   // The skid only fills when the result register is held by rsp_stall,
   // so while it is full the input side is stalled.
   logic    out_valid_ff,  out_valid_in;
   rsp_type out_ff,        out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff,       skid_in;
   logic    out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // no beat accepted this cycle, so nothing new arrives
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // skid never holds a beat behind an empty result register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   // stray groups are never empty and never exceed the group size
   a_stray_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == ST_STRAY) |->
      (out_ff.byte_count != '0 &&
       out_ff.byte_count <= BYTE_COUNT_W'(STRAY_LIMIT)))
      else $error("stray group count out of range");

   // length rejects always report the start and length bytes only
   a_len_reject: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.status == ST_SHORT_LEN ||
                        out_ff.status == ST_LONG_LEN)) |->
      (out_ff.byte_count == BYTE_COUNT_W'(2)))
      else $error("length reject with wrong byte count");
`endif

endmodule

### tb/sum_checked_frame_deframer_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// sum_checked_frame_deframer_tb
// Self-checking bench for the start/length/checksum/end frame deframer.
// A short directed table runs first, with pinned results for the obvious rows.
// Then come random phases, mostly well-formed frames with random payload and
// some noise, under several CSR settings. An in-bench frame parser predicts
// each status report. Both channels idle at random, and once the receiver
// holds off long enough for the block to stall its input.
// -----------------------------------------------------------------------------
module sum_checked_frame_deframer_tb;
   import scd_pkg::*;

   localparam int STRAY_LIMIT     = 16;
   localparam int MAX_FRAME_BYTES = 64;
   localparam int CYCLE_LIMIT     = 200_000;
   localparam int PHASE_BEATS     = 250;
   localparam int HOLD_AT_BEAT    = 350;   // long receiver hold-off starts here
   localparam int HOLD_CYCLES     = 300;
   localparam int CALM_FROM       = 600;   // no idling on either side in this window
   localparam int CALM_TO         = 800;
   localparam int DRAIN_CYCLES    = 4;     // result register plus skid, with margin

   // The op field is two bits wide; code 3 is not a real event and is dropped.
   localparam op_type OP_IGNORED = op_type'(2'b11);

   // How a beat's report is checked: from the parser, or typed in by hand
   typedef enum logic [1:0] {
      CHECK_MODEL,
      PIN_NONE,
      PIN_RESULT
   } check_mode_type;

   // Damage applied to a random frame
   typedef enum logic [1:0] {
      FLAW_NONE,
      FLAW_END,
      FLAW_SUM,
      FLAW_CUT
   } flaw_type;

   typedef struct {
      req_type        beat;
      check_mode_type mode;
      rsp_type        pinned;
   } stim_row_type;

   // DUT hookup; every input starts at a known value
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we    = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   sum_checked_frame_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Parser copy of the CSRs
   logic [7:0] cfg_start = START_MARKER_RST;
   logic [7:0] cfg_end   = END_MARKER_RST;
   logic [5:0] cfg_max   = MAX_LENGTH_RST;
   logic [6:0] cfg_telem = TELEM_TOTAL_RST;

   // Parser state
   logic [6:0] frame_pos  = '0;   // 0 = no frame open
   logic [5:0] len_field  = '0;
   logic [7:0] run_sum    = '0;
   logic [7:0] last_byte  = '0;   // at the end byte this is the claimed checksum
   logic [7:0] spd_hi     = '0;
   logic [7:0] spd_lo     = '0;
   logic [7:0] steps      = '0;
   logic [4:0] stray_held = '0;

   rsp_type        status_due [$];     // reports owed by the block, oldest first
   stim_row_type   stim_q [$];
   stim_row_type   directed [$];

   // Check mode of the beat on the bus, set by the driver with the payload
   check_mode_type live_mode   = CHECK_MODEL;
   rsp_type        live_pinned = '0;

   int accepted_beats = 0;
   int reports_seen   = 0;
   int mismatches     = 0;
   int cycle_count    = 0;
   int settings_used  = 1;
   int seen_by_status [9];

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Idle roll shared by both sides; quiet inside the calm window
   function automatic logic idle_roll();
      if (accepted_beats >= CALM_FROM && accepted_beats < CALM_TO)
         return 1'b0;
      return $urandom_range(99) < 26;
   endfunction

   task automatic log_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
      $display("MISMATCH report %0d: %s got 0x%0h want 0x%0h", reports_seen, what, got,
               want);
      mismatches++;
   endtask

   // Frame parser: one event beat in, at most one status report out
   task automatic deframe_event(input req_type d, output logic hit, output rsp_type r);
      int total;
      int idx;
      logic [7:0] b;
      hit = 1'b0;
      r   = '0;
      b   = d.byte_value;
      case (d.operation)
         OP_BYTE: begin
            if (frame_pos == 0) begin
               if (b != cfg_start) begin
                  // stray byte; a full group is flushed and this byte starts the next
                  if (stray_held >= STRAY_LIMIT) begin
                     hit          = 1'b1;
                     r.status     = ST_STRAY;
                     r.byte_count = 7'(stray_held);
                     stray_held   = 5'd1;
                  end else begin
                     stray_held = stray_held + 5'd1;
                  end
               end else begin
                  frame_pos = 7'd1;
                  run_sum   = '0;
                  len_field = '0;
                  last_byte = b;
                  spd_hi    = '0;
                  spd_lo    = '0;
                  steps     = '0;
                  if (stray_held > 0) begin
                     hit          = 1'b1;
                     r.status     = ST_STRAY;
                     r.byte_count = 7'(stray_held);
                     stray_held   = '0;
                  end
               end
            end else if (frame_pos == 1) begin
               // length byte
               frame_pos = '0;
               if (b < 2) begin
                  hit          = 1'b1;
                  r.status     = ST_SHORT_LEN;
                  r.byte_count = 7'd2;
               end else if (b > cfg_max || b + 2 > MAX_FRAME_BYTES) begin
                  hit          = 1'b1;
                  r.status     = ST_LONG_LEN;
                  r.byte_count = 7'd2;
               end else begin
                  len_field = b[5:0];
                  run_sum   = b;
                  last_byte = b;
                  frame_pos = 7'd2;
               end
            end else begin
               idx   = frame_pos;
               total = len_field + 2;
               if (idx == 3) spd_hi = b;
               if (idx == 4) spd_lo = b;
               if (idx == 6) steps  = b;
               if (idx + 3 <= total) run_sum = run_sum + b;
               if (idx + 1 < total) begin
                  last_byte = b;
                  frame_pos = 7'(idx + 1);
               end else begin
                  // end byte: end marker is checked before the checksum
                  frame_pos      = '0;
                  hit            = 1'b1;
                  r.byte_count   = 7'(total);
                  r.computed_sum = run_sum;
                  r.end_seen     = b;
                  if (b != cfg_end) begin
                     r.status = ST_BAD_END;
                  end else if (last_byte != run_sum) begin
                     r.status = ST_BAD_SUM;
                  end else if (total == cfg_telem) begin
                     r.status      = ST_TELEMETRY;
                     r.speed_value = {spd_hi, spd_lo};
                     r.step_count  = steps;
                  end else begin
                     r.status = ST_OK;
                  end
               end
            end
         end
         OP_TIMEOUT, OP_OVERFLOW: begin
            // abandon: open frame first, else held strays, else nothing
            if (frame_pos > 0) begin
               hit          = 1'b1;
               r.status     = (d.operation == OP_TIMEOUT) ? ST_TIMEOUT : ST_OVERFLOW;
               r.byte_count = frame_pos;
               frame_pos    = '0;
            end else if (stray_held > 0) begin
               hit          = 1'b1;
               r.status     = ST_STRAY;
               r.byte_count = 7'(stray_held);
               stray_held   = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Result check, then prediction for the beat accepted at this edge
   always @(posedge clock) begin : beat_monitor
      rsp_type want;
      rsp_type made;
      logic    hit;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (int'(rsp_data.status) < 9) seen_by_status[int'(rsp_data.status)]++;
         if (status_due.size() == 0) begin
            log_mismatch("report with none due, status", rsp_data.status, '0);
         end else begin
            want = status_due.pop_front();
            if (rsp_data.status !== want.status)
               log_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.byte_count !== want.byte_count)
               log_mismatch("byte_count", rsp_data.byte_count, want.byte_count);
            if (rsp_data.speed_value !== want.speed_value)
               log_mismatch("speed_value", rsp_data.speed_value, want.speed_value);
            if (rsp_data.step_count !== want.step_count)
               log_mismatch("step_count", rsp_data.step_count, want.step_count);
            if (rsp_data.computed_sum !== want.computed_sum)
               log_mismatch("computed_sum", rsp_data.computed_sum, want.computed_sum);
            if (rsp_data.end_seen !== want.end_seen)
               log_mismatch("end_seen", rsp_data.end_seen, want.end_seen);
         end
      end
      if (!reset && req_valid && !req_stall) begin
         accepted_beats++;
         deframe_event(req_data, hit, made);
         // the parser always steps so its state stays in line with pinned rows
         case (live_mode)
            PIN_NONE:   ;
            PIN_RESULT: status_due.push_back(live_pinned);
            default:    if (hit) status_due.push_back(made);
         endcase
      end
   end

   // Receiver: random stall, plus one long hold-off to back the block up
   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && accepted_beats >= HOLD_AT_BEAT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idle_roll();
         end
      end
   end

   function automatic stim_row_type mk_row(input op_type op, input logic [7:0] b,
                                           input check_mode_type m = CHECK_MODEL,
                                           input status_type st = ST_TELEMETRY,
                                           input int cnt = 0, input int spd = 0,
                                           input int stp = 0, input int sm = 0,
                                           input int eb = 0);
      stim_row_type row;
      row.beat.operation    = op;
      row.beat.byte_value   = b;
      row.mode              = m;
      row.pinned            = '0;
      row.pinned.status     = st;
      row.pinned.byte_count = 7'(cnt);
      row.pinned.speed_value = 16'(spd);
      row.pinned.step_count = 8'(stp);
      row.pinned.computed_sum = 8'(sm);
      row.pinned.end_seen   = 8'(eb);
      return row;
   endfunction

   task automatic push_event(input op_type op, input logic [7:0] b);
      stim_q.push_back(mk_row(op, b));
   endtask

   // Send every queued beat; valid holds while stalled, then drops at the end
   task automatic drive_all();
      stim_row_type row;
      while (stim_q.size() != 0) begin
         row = stim_q.pop_front();
         while (idle_roll()) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_data    <= row.beat;
         live_mode    = row.mode;
         live_pinned  = row.pinned;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   // Wait out every owed report, then the block's own latency
   task automatic settle();
      while (status_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_START_MARKER: cfg_start = val;
         CSR_END_MARKER:   cfg_end   = val;
         CSR_MAX_LENGTH:   cfg_max   = val[5:0];
         CSR_TELEM_TOTAL:  cfg_telem = val[6:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] start_b, input logic [7:0] end_b,
                                 input logic [7:0] max_len, input logic [7:0] telem);
      settle();
      csr_write(CSR_START_MARKER, start_b);
      csr_write(CSR_END_MARKER, end_b);
      csr_write(CSR_MAX_LENGTH, max_len);
      csr_write(CSR_TELEM_TOTAL, telem);
      settings_used++;
   endtask

   // One frame with random payload; the checksum is right unless damaged
   task automatic queue_frame(input int len, input flaw_type flaw);
      logic [7:0] frame [$];
      logic [7:0] sum;
      int keep;
      frame.push_back(cfg_start);
      frame.push_back(8'(len));
      sum = 8'(len);
      repeat (len - 2) begin
         frame.push_back(8'($urandom));
         sum = sum + frame[$];
      end
      frame.push_back(flaw == FLAW_SUM ? sum + 8'($urandom_range(255, 1)) : sum);
      frame.push_back(flaw == FLAW_END ? cfg_end ^ 8'($urandom_range(255, 1)) : cfg_end);
      keep = (flaw == FLAW_CUT) ? $urandom_range(frame.size() - 1, 1) : frame.size();
      for (int i = 0; i < keep; i++) push_event(OP_BYTE, frame[i]);
      if (flaw == FLAW_CUT)
         push_event($urandom_range(1) ? OP_TIMEOUT : OP_OVERFLOW, 8'($urandom));
   endtask

   // Mostly well-formed frames; the rest is bad lengths, stray runs and noise
   task automatic random_phase(input int n_beats);
      int target;
      int pick;
      int roll;
      int len;
      int max_ok;
      int short_cap;
      flaw_type flaw;
      logic [7:0] b;
      target = stim_q.size() + n_beats;
      while (stim_q.size() < target) begin
         pick      = $urandom_range(99);
         max_ok    = (cfg_max > 62) ? 62 : cfg_max;
         short_cap = (max_ok < 12) ? max_ok : 12;
         if (pick < 60) begin
            roll = $urandom_range(99);
            if (roll < 20 && cfg_telem >= 4 && cfg_telem - 2 <= max_ok)
               len = cfg_telem - 2;
            else if (roll < 30)
               len = max_ok;
            else
               len = $urandom_range(short_cap, 2);
            roll = $urandom_range(99);
            flaw = (roll < 70) ? FLAW_NONE : (roll < 80) ? FLAW_END :
                   (roll < 90) ? FLAW_SUM : FLAW_CUT;
            queue_frame(len, flaw);
         end else if (pick < 70) begin
            push_event(OP_BYTE, cfg_start);
            if ($urandom_range(99) < 40 || cfg_max == 6'd63)
               push_event(OP_BYTE, 8'($urandom_range(1)));
            else
               push_event(OP_BYTE, 8'($urandom_range(255, cfg_max + 1)));
            if (cfg_max == 6'd63 && $urandom_range(1)) begin
               push_event(OP_BYTE, cfg_start);
               push_event(OP_BYTE, 8'd63);
            end
         end else if (pick < 85) begin
            // stray run, long enough at times to overflow a group
            repeat ($urandom_range(40, 1)) begin
               b = 8'($urandom);
               if (b == cfg_start) b = b ^ 8'h01;
               push_event(OP_BYTE, b);
            end
         end else begin
            roll = $urandom_range(2);
            push_event(roll == 0 ? OP_TIMEOUT : roll == 1 ? OP_OVERFLOW : OP_IGNORED,
                       8'($urandom));
         end
      end
      drive_all();
   endtask

   // Main sequence
   initial begin
      // Directed table, reset settings: start 0x68, end 0x43, max 62, telemetry 14
      directed.push_back(mk_row(OP_TIMEOUT, 8'h00, PIN_NONE));       // nothing pending
      directed.push_back(mk_row(OP_IGNORED, 8'hFF, PIN_NONE));       // code 3 dropped
      directed.push_back(mk_row(OP_BYTE, 8'hFF, PIN_NONE));          // stray
      directed.push_back(mk_row(OP_BYTE, 8'h00, PIN_NONE));          // stray
      directed.push_back(mk_row(OP_OVERFLOW, 8'h00, PIN_RESULT, ST_STRAY, 2));
      directed.push_back(mk_row(OP_BYTE, 8'h68, PIN_NONE));
      directed.push_back(mk_row(OP_BYTE, 8'h01, PIN_RESULT, ST_SHORT_LEN, 2));
      directed.push_back(mk_row(OP_BYTE, 8'h68, PIN_NONE));
      directed.push_back(mk_row(OP_BYTE, 8'h3F, PIN_RESULT, ST_LONG_LEN, 2));
      // telemetry frame, 14 bytes: speed 0x1234 in bytes 3/4, steps 0x56 in byte 6
      directed.push_back(mk_row(OP_BYTE, 8'h68));
      directed.push_back(mk_row(OP_BYTE, 8'h0C));
      directed.push_back(mk_row(OP_BYTE, 8'h00));
      directed.push_back(mk_row(OP_BYTE, 8'h12));
      directed.push_back(mk_row(OP_BYTE, 8'h34));
      directed.push_back(mk_row(OP_BYTE, 8'h00));
      directed.push_back(mk_row(OP_BYTE, 8'h56));
      repeat (5) directed.push_back(mk_row(OP_BYTE, 8'h00));
      directed.push_back(mk_row(OP_BYTE, 8'hA8));
      directed.push_back(mk_row(OP_BYTE, 8'h43, PIN_RESULT, ST_TELEMETRY, 14, 16'h1234,
                                8'h56, 8'hA8, 8'h43));
      // frame cut short by a timeout after its length byte
      directed.push_back(mk_row(OP_BYTE, 8'h68));
      directed.push_back(mk_row(OP_BYTE, 8'h02));
      directed.push_back(mk_row(OP_TIMEOUT, 8'h00, PIN_RESULT, ST_TIMEOUT, 2));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) stim_q.push_back(directed[i]);
      random_phase(PHASE_BEATS);

      // start marker at its low extreme, end marker at its high one, telemetry total 7
      apply_settings(8'h00, 8'hFF, 8'd62, 8'd7);
      random_phase(PHASE_BEATS);
      // shortest legal length only; telemetry shape shorter than its fields
      apply_settings(8'hFF, 8'h00, 8'd2, 8'd4);
      random_phase(PHASE_BEATS);
      // length field 63 passes the register but not the frame size limit
      apply_settings(8'h7E, 8'h7E, 8'd63, 8'd64);
      random_phase(PHASE_BEATS);
      apply_settings(8'h55, 8'hAA, 8'd5, 8'd5);
      random_phase(PHASE_BEATS);

      settle();
      $display("Run: %0d event beats, %0d status reports, %0d CSR settings, %0d cycles",
               accepted_beats, reports_seen, settings_used, cycle_count);
      $display("Reports: telemetry %0d, ok %0d, bad length %0d, bad end/sum %0d, %s %0d",
               seen_by_status[0], seen_by_status[1], seen_by_status[2] + seen_by_status[3],
               seen_by_status[4] + seen_by_status[5], "stray/abandon",
               seen_by_status[6] + seen_by_status[7] + seen_by_status[8]);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
